// ----- hdl/tbrl_pkg.sv -----
// Shared types and constants for the token bucket rate limiter.
package tbrl_pkg;

    localparam int TOKEN_W = 36;
    localparam int TIME_W  = 64;
    localparam int DROP_W  = 32;
    localparam int RATE_W  = 16;

    typedef logic [TOKEN_W-1:0] token_t;
    typedef logic [TIME_W-1:0]  stamp_t;
    typedef logic [DROP_W-1:0]  drops_t;
    typedef logic [RATE_W-1:0]  rate_t;

    // one full token, scaled by one million
    localparam token_t TOKEN_SCALE = 36'd1000000;
    // elapsed times below one second fit in this many bits
    localparam int ELAP_W = 20;

    typedef struct packed {
        logic   valid;
        stamp_t last_time;
        token_t tokens;
    } bucket_t;

    typedef struct packed {
        logic cap_en;
        logic elap_en;
        logic lvl_en;
    } refill_ctl_t;

endpackage

// ----- hdl/tbrl_bucket_mem.sv -----
// Bucket state memory: one write port, one registered read port.
module tbrl_bucket_mem #(
    parameter int DEPTH = 384,
    parameter int AW    = 9
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  tbrl_pkg::bucket_t wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output tbrl_pkg::bucket_t rdata
);
    import tbrl_pkg::*;

    bucket_t bucket_mem_reg [DEPTH];
    bucket_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            bucket_mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= bucket_mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/tbrl_refill.sv -----
// Refill and spend datapath, split into registered steps.
module tbrl_refill (
    input  logic                  clk,
    input  tbrl_pkg::refill_ctl_t ctl,
    input  tbrl_pkg::rate_t       rate,
    input  tbrl_pkg::stamp_t      now,
    input  tbrl_pkg::bucket_t     bucket,
    output logic                  admit,
    output tbrl_pkg::token_t      new_tokens
);
    import tbrl_pkg::*;

    token_t              cap_reg;
    token_t              prod_reg;
    token_t              tok_reg;
    logic                full_reg;
    token_t              level_reg;
    stamp_t              elapsed;
    logic [TOKEN_W:0]    sum;

    assign elapsed = now - bucket.last_time;
    assign sum     = {1'b0, tok_reg} + {1'b0, prod_reg};

    always_ff @(posedge clk)
    begin
        if (ctl.cap_en)
        begin
            cap_reg <= TOKEN_W'(rate) * TOKEN_SCALE;
        end
        if (ctl.elap_en)
        begin
            // a fresh bucket or a gap of a second or more refills to capacity
            full_reg <= !bucket.valid || (elapsed >= TIME_W'(TOKEN_SCALE));
            prod_reg <= TOKEN_W'(rate) * TOKEN_W'(elapsed[ELAP_W-1:0]);
            tok_reg  <= bucket.tokens;
        end
        if (ctl.lvl_en)
        begin
            if (full_reg || (sum > {1'b0, cap_reg}))
            begin
                level_reg <= cap_reg;
            end
            else
            begin
                level_reg <= sum[TOKEN_W-1:0];
            end
        end
    end

    assign admit      = (level_reg >= TOKEN_SCALE);
    assign new_tokens = admit ? (level_reg - TOKEN_SCALE) : level_reg;

endmodule

// ----- hdl/tbrl_drop_ctr.sv -----
// Per-channel wrapping drop counters.
module tbrl_drop_ctr #(
    parameter int CHANNELS = 3,
    parameter int CH_W     = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                bump,
    input  logic [CH_W-1:0]     sel,
    output tbrl_pkg::drops_t    count_after
);
    import tbrl_pkg::*;

    drops_t cnt_reg [CHANNELS];

    assign count_after = cnt_reg[sel] + DROP_W'(bump);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (bump)
        begin
            cnt_reg[sel] <= count_after;
        end
    end

endmodule

// ----- hdl/token_bucket_rate_limiter_top.sv -----
// Top level of the token bucket rate limiter: control sequencer and state memory.
//
//  channel   direction  handshake            payload
//  request   in         start && !busy       entry_index, channel, rate_limit_hz, now_time_us
//  result    out        done (one cycle)     admitted, drop_count, tokens_left
//
// A request that touches a bucket goes from acceptance to its done strobe
// through memory read, elapsed time and refill product, level saturation,
// spend and write-back, then the registered result. The steps follow the
// read-modify-write of the bucket memory. Requests with rate zero, an entry
// beyond the table or a channel beyond the counters go through S_FAST instead.
// After reset the block sweeps the bucket memory to clear its valid flags,
// one entry a cycle, all ENTRIES*CHANNELS entries, with busy high.
// The receiver cannot stall: each result is shown for exactly one cycle.
module token_bucket_rate_limiter_top #(
    parameter int ENTRIES  = 128,
    parameter int CHANNELS = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [7:0]             entry_index,
    input  logic [1:0]             channel,
    input  tbrl_pkg::rate_t        rate_limit_hz,
    input  tbrl_pkg::stamp_t       now_time_us,
    output logic                   done,
    output logic                   admitted,
    output tbrl_pkg::drops_t       drop_count,
    output tbrl_pkg::token_t       tokens_left
);
    import tbrl_pkg::*;

    localparam int NBUCKETS = ENTRIES * CHANNELS;
    localparam int SLOT_W   = (NBUCKETS > 1) ? $clog2(NBUCKETS) : 1;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_FAST = 7'b0000100,
        S_RD   = 7'b0001000,
        S_EL   = 7'b0010000,
        S_LV   = 7'b0100000,
        S_WB   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [SLOT_W-1:0] clr_cnt_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [1:0]        channel_reg;
    rate_t             rate_reg;
    stamp_t            now_reg;
    logic              ch_ok_reg;

    logic              done_reg;
    logic              admitted_reg;
    drops_t            drop_count_reg;
    token_t            tokens_left_reg;

    logic              accept;
    logic              ch_ok;
    logic              entry_ok;

    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    bucket_t           mem_wdata;
    bucket_t           mem_rdata;

    refill_ctl_t       rctl;
    logic              spend_ok;
    token_t            spend_tokens;

    logic              drop_bump;
    drops_t            drop_after;

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign ch_ok    = (32'(channel) < CHANNELS);
    assign entry_ok = (32'(entry_index) < ENTRIES);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                if (clr_cnt_reg == SLOT_W'(NBUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    // only a live channel with a nonzero rate and an entry
                    // inside the table has a bucket to update
                    if (ch_ok && entry_ok && (rate_limit_hz != '0))
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_FAST;
                    end
                end
            end
            S_FAST:  state_next = S_IDLE;
            S_RD:    state_next = S_EL;
            S_EL:    state_next = S_LV;
            S_LV:    state_next = S_WB;
            S_WB:    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
            begin
                clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
            end
            done_reg <= (state_reg == S_FAST) || (state_reg == S_WB);
        end
    end

    // Latch the request transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            channel_reg <= channel;
            rate_reg    <= rate_limit_hz;
            now_reg     <= now_time_us;
            ch_ok_reg   <= ch_ok;
            slot_reg    <= SLOT_W'(32'(entry_index) * CHANNELS + 32'(channel));
        end
    end

    // Bucket memory: clear sweep after reset, write-back at the end of an update
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = slot_reg;
        mem_wdata = '0;
        case (state_reg)
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
            end
            S_WB:
            begin
                mem_we              = 1'b1;
                mem_wdata.valid     = 1'b1;
                mem_wdata.last_time = now_reg;
                mem_wdata.tokens    = spend_tokens;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    tbrl_bucket_mem #(
        .DEPTH (NBUCKETS),
        .AW    (SLOT_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (state_reg == S_RD),
        .raddr (slot_reg),
        .rdata (mem_rdata)
    );

    assign rctl.cap_en  = (state_reg == S_RD);
    assign rctl.elap_en = (state_reg == S_EL);
    assign rctl.lvl_en  = (state_reg == S_LV);

    tbrl_refill u_refill (
        .clk        (clk),
        .ctl        (rctl),
        .rate       (rate_reg),
        .now        (now_reg),
        .bucket     (mem_rdata),
        .admit      (spend_ok),
        .new_tokens (spend_tokens)
    );

    // Count a drop on a bucket that ran dry, or on a live channel with rate zero
    assign drop_bump = ((state_reg == S_WB) && !spend_ok) ||
                       ((state_reg == S_FAST) && ch_ok_reg && (rate_reg == '0));

    tbrl_drop_ctr #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_drops (
        .clk         (clk),
        .rst_n       (rst_n),
        .bump        (drop_bump),
        .sel         (CH_W'(channel_reg)),
        .count_after (drop_after)
    );

    // Result registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WB)
        begin
            admitted_reg    <= spend_ok;
            drop_count_reg  <= drop_after;
            tokens_left_reg <= spend_tokens;
        end
        else if (state_reg == S_FAST)
        begin
            admitted_reg    <= (rate_reg != '0);
            drop_count_reg  <= ch_ok_reg ? drop_after : '0;
            tokens_left_reg <= '0;
        end
    end

    assign done        = done_reg;
    assign admitted    = admitted_reg;
    assign drop_count  = drop_count_reg;
    assign tokens_left = tokens_left_reg;

    // Checks
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after an accepted request");

    a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_WB || state_reg == S_FAST))
        else $error("result strobe without a finishing step");

    a_tokens_cap: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (tokens_left <= 36'd65535000000))
        else $error("tokens above the largest capacity");

    a_mem_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_WB || state_reg == S_CLR))
        else $error("bucket memory written outside sweep or write-back");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the token bucket rate limiter top level.
`timescale 1ns / 100ps

module testbench;

    import tbrl_pkg::*;

    localparam int ENTRIES      = 128;
    localparam int CHANNELS     = 3;
    localparam int NBKT         = ENTRIES * CHANNELS;
    localparam int RANDOM_ITEMS = 450;
    localparam int HOT_SET      = 8;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 20;
    localparam int REPORT_MAX   = 10;
    localparam logic [63:0] ONE_TOKEN = 64'(TOKEN_SCALE);

    // One request transaction as the sender holds it, plus its pacing.
    typedef struct {
        logic [7:0]  entry;
        logic [1:0]  chan;
        rate_t       rate;
        stamp_t      now;
        int unsigned gap;    // idle cycles before it is presented
        bit          drain;  // present only once every result is back
    } rl_req_t;

    // Predicted outcome of one request, with the request kept for reports.
    typedef struct {
        logic    admit;
        drops_t  drops;
        token_t  tokens;
        rl_req_t req;
    } rl_verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [7:0]  entry_index = '0;
    logic [1:0]  channel = '0;
    rate_t       rate_limit_hz = '0;
    stamp_t      now_time_us = '0;
    logic        busy;
    logic        done;
    logic        admitted;
    drops_t      drop_count;
    token_t      tokens_left;

    // Predictor state: bucket table and per-channel drop counters.
    bit          bkt_seen [NBKT];
    stamp_t      bkt_stamp [NBKT];
    token_t      bkt_level [NBKT];
    drops_t      chan_drops [CHANNELS];

    rl_req_t     request_q [$];
    rl_verdict_t verdict_q [$];

    int unsigned issued_cnt = 0;   // requests accepted by the block
    int unsigned verdict_cnt = 0;  // result strobes seen
    int unsigned hold_cnt = 0;
    int unsigned error_cnt = 0;
    int unsigned admit_seen = 0;
    int unsigned drop_seen = 0;
    int unsigned quiet_left = 0;
    bit          took;
    rl_req_t     cur_req;
    rl_req_t     nxt_req;
    rl_verdict_t want;
    rl_verdict_t got;

    token_bucket_rate_limiter_top #(
        .ENTRIES  (ENTRIES),
        .CHANNELS (CHANNELS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .entry_index   (entry_index),
        .channel       (channel),
        .rate_limit_hz (rate_limit_hz),
        .now_time_us   (now_time_us),
        .done          (done),
        .admitted      (admitted),
        .drop_count    (drop_count),
        .tokens_left   (tokens_left)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the outcome of one request and advance the bucket table.
    function automatic rl_verdict_t meter_request(input rl_req_t q);
        rl_verdict_t r;
        int          slot;
        logic [63:0] cap;
        logic [63:0] elapsed;
        logic [63:0] level;
        r = '{admit: 1'b0, drops: '0, tokens: '0, req: q};
        // no bucket and no counter behind an unknown channel
        if (q.chan >= CHANNELS)
        begin
            r.admit = (q.rate != '0);
            return r;
        end
        if (q.rate == '0)
        begin
            r.admit = 1'b0;
        end
        else if (q.entry >= ENTRIES)
        begin
            r.admit = 1'b1;
        end
        else
        begin
            slot = int'(q.entry) * CHANNELS + int'(q.chan);
            cap  = 64'(q.rate) * ONE_TOKEN;
            // a fresh bucket starts full, stamped now
            if (!bkt_seen[slot])
            begin
                bkt_seen[slot]  = 1'b1;
                bkt_stamp[slot] = q.now;
                bkt_level[slot] = cap[TOKEN_W-1:0];
            end
            // elapsed wraps modulo 2^64, so a backward step looks huge
            elapsed = q.now - bkt_stamp[slot];
            bkt_stamp[slot] = q.now;
            if (elapsed >= ONE_TOKEN)
            begin
                level = cap;
            end
            else
            begin
                level = 64'(bkt_level[slot]) + 64'(q.rate) * elapsed;
                if (level > cap)
                    level = cap;
            end
            if (level < ONE_TOKEN)
            begin
                bkt_level[slot] = level[TOKEN_W-1:0];
                r.admit = 1'b0;
            end
            else
            begin
                level = level - ONE_TOKEN;
                bkt_level[slot] = level[TOKEN_W-1:0];
                r.admit = 1'b1;
            end
            r.tokens = bkt_level[slot];
        end
        if (!r.admit)
            chan_drops[q.chan] = chan_drops[q.chan] + 1'b1;
        r.drops = chan_drops[q.chan];
        return r;
    endfunction

    function void flag_error(input string msg);
        if (error_cnt < REPORT_MAX)
            $display("ERROR @%0t: %s", $time, msg);
        error_cnt++;
    endfunction

    // Draw the sender's pause before an item; quiet stretches run back to back.
    function automatic int unsigned next_gap();
        if (quiet_left != 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            quiet_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // Favor low rates so buckets actually run dry between requests.
    function automatic rate_t pick_rate();
        case ($urandom_range(0, 3))
            0, 1:    return rate_t'($urandom_range(1, 50));
            2:       return rate_t'($urandom_range(51, 2000));
            default: return rate_t'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic stamp_t any_stamp();
        return {$urandom, $urandom};
    endfunction

    task automatic add_request(input logic [7:0] ent, input logic [1:0] ch, input rate_t r,
                               input stamp_t t, input bit drain);
        rl_req_t q;
        q.entry = ent;
        q.chan  = ch;
        q.rate  = r;
        q.now   = t;
        q.gap   = next_gap();
        q.drain = drain;
        request_q.push_back(q);
    endtask

    // Driver: a transaction is taken at an edge with start high and busy low.
    // Predict it right there, then hold, pause or present the next one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            took = start && !busy;
            if (took)
            begin
                cur_req.entry = entry_index;
                cur_req.chan  = channel;
                cur_req.rate  = rate_limit_hz;
                cur_req.now   = now_time_us;
                cur_req.gap   = 0;
                cur_req.drain = 1'b0;
                want = meter_request(cur_req);
                verdict_q.push_back(want);
                issued_cnt <= issued_cnt + 1;
            end
            if (start && !took)
            begin
                // hold the transaction until the block takes it
            end
            else if (request_q.size() == 0)
            begin
                start <= 1'b0;
            end
            else if (hold_cnt < request_q[0].gap)
            begin
                hold_cnt <= hold_cnt + 1;
                start    <= 1'b0;
            end
            else if (request_q[0].drain && (verdict_cnt < issued_cnt + (took ? 1 : 0)))
            begin
                // drain: wait for every outstanding result first
                start <= 1'b0;
            end
            else
            begin
                nxt_req = request_q.pop_front();
                entry_index   <= nxt_req.entry;
                channel       <= nxt_req.chan;
                rate_limit_hz <= nxt_req.rate;
                now_time_us   <= nxt_req.now;
                start         <= 1'b1;
                hold_cnt      <= 0;
            end
        end
    end

    // Monitor: each done strobe carries one result, compared against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            verdict_cnt <= verdict_cnt + 1;
            if (verdict_q.size() == 0)
            begin
                flag_error($sformatf("result with nothing pending: admitted=%0b drops=%0d tokens=%0d",
                                     admitted, drop_count, tokens_left));
            end
            else
            begin
                got = verdict_q.pop_front();
                if (admitted !== got.admit || drop_count !== got.drops
                    || tokens_left !== got.tokens)
                begin
                    flag_error($sformatf({"entry=%0d ch=%0d rate=%0d now=%0h: ",
                                          "admitted %0b/%0b drops %0d/%0d tokens %0d/%0d ",
                                          "(expected/actual)"},
                                         got.req.entry, got.req.chan, got.req.rate, got.req.now,
                                         got.admit, admitted, got.drops, drop_count,
                                         got.tokens, tokens_left));
                end
            end
            if (admitted === 1'b1)
                admit_seen++;
            else
                drop_seen++;
        end
    end

    // Stimulus, reset and orderly end of the run.
    initial
    begin
        logic [7:0]  hot_ent [HOT_SET];
        rate_t       hot_rate [HOT_SET][CHANNELS];
        stamp_t      gen_now;
        stamp_t      t0;
        int unsigned pick;
        int unsigned hs;
        int unsigned hc;
        int unsigned span;
        int unsigned total;
        int unsigned waited;
        int unsigned touched;
        rate_t       r;
        bit          drain_here;

        // drop counters start at zero, as the block's do after reset
        foreach (chan_drops[c])
            chan_drops[c] = '0;

        // Directed: drain a slow bucket, then refill it one microsecond short and exact.
        t0 = 64'd5000;
        add_request(8'd0, 2'd0, 16'd1, t0, 1'b0);
        add_request(8'd0, 2'd0, 16'd1, t0, 1'b0);
        add_request(8'd0, 2'd0, 16'd1, t0 + 64'd999999, 1'b0);
        add_request(8'd0, 2'd0, 16'd1, t0 + 64'd1000000, 1'b0);
        add_request(8'd0, 2'd0, 16'd1, t0 + 64'd4000000, 1'b0);
        // rate zero, entries beyond the table, channel beyond the counters
        add_request(8'd0, 2'd0, 16'd0, t0 + 64'd4000001, 1'b0);
        add_request(8'd128, 2'd1, 16'd500, 64'd77, 1'b0);
        add_request(8'd255, 2'd2, 16'hFFFF, '1, 1'b0);
        add_request(8'd5, 2'd3, 16'd0, 64'd123, 1'b0);
        add_request(8'd200, 2'd3, 16'hFFFF, '1, 1'b0);
        // top rate, time wrapping past 2^64, a backward step, then a rate cut
        add_request(8'd127, 2'd2, 16'hFFFF, '1, 1'b0);
        add_request(8'd127, 2'd2, 16'hFFFF, 64'd10, 1'b0);
        add_request(8'd127, 2'd2, 16'hFFFF, 64'd5, 1'b0);
        add_request(8'd127, 2'd2, 16'd1, 64'd6, 1'b0);
        add_request(8'd127, 2'd2, 16'd1, 64'd6, 1'b0);
        // a two-token bucket spent out at one instant
        add_request(8'd1, 2'd1, 16'd2, 64'd900, 1'b0);
        add_request(8'd1, 2'd1, 16'd2, 64'd900, 1'b0);
        add_request(8'd1, 2'd1, 16'd2, 64'd900, 1'b0);
        t0 = any_stamp();
        add_request(8'd64, 2'd0, 16'hFFFF, t0, 1'b0);
        add_request(8'd64, 2'd0, 16'hFFFF, t0 + 64'd15, 1'b1);

        // Random: mostly steady traffic on a few hot buckets, paced near their rate,
        // with the shared clock starting close below the 2^64 wrap.
        for (int i = 0; i < HOT_SET; i++)
        begin
            hot_ent[i] = 8'($urandom_range(0, ENTRIES - 1));
            for (int c = 0; c < CHANNELS; c++)
                hot_rate[i][c] = pick_rate();
        end
        gen_now = 64'hFFFF_FFFF_F800_0000;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick       = $urandom_range(0, 99);
            hs         = $urandom_range(0, HOT_SET - 1);
            hc         = $urandom_range(0, CHANNELS - 1);
            drain_here = (n == RANDOM_ITEMS / 2);
            if (pick < 78)
            begin
                if ($urandom_range(0, 19) == 0)
                    hot_rate[hs][hc] = pick_rate();
                r    = hot_rate[hs][hc];
                span = 2000000 / r + 1;
                if ($urandom_range(0, 9) != 0)
                    gen_now = gen_now + $urandom_range(0, span);
                add_request(hot_ent[hs], 2'(hc), r, gen_now, drain_here);
            end
            else if (pick < 90)
            begin
                case ($urandom_range(0, 2))
                    0:       add_request(8'($urandom), 2'($urandom), '0, any_stamp(),
                                         drain_here);
                    1:       add_request(8'($urandom_range(ENTRIES, 255)), 2'($urandom),
                                         rate_t'($urandom), any_stamp(), drain_here);
                    default: add_request(8'($urandom), 2'd3, rate_t'($urandom), any_stamp(),
                                         drain_here);
                endcase
            end
            else if (pick < 96)
            begin
                add_request(8'($urandom_range(0, ENTRIES - 1)), 2'(hc), rate_t'($urandom),
                            gen_now, drain_here);
            end
            else
            begin
                // wild jump on a hot bucket: long or backward gap
                add_request(hot_ent[hs], 2'(hc), hot_rate[hs][hc], any_stamp(), drain_here);
            end
        end
        total = request_q.size();

        // Hold reset, then release it; the block then clears its table with busy high.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Advance until every transaction is taken, then until every result is back or the drain limit runs out.
        do
            @(posedge clk);
        while (issued_cnt < total);
        waited = 0;
        while (verdict_cnt < issued_cnt && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (verdict_q.size() != 0)
            flag_error($sformatf("%0d predicted results never arrived", verdict_q.size()));

        touched = 0;
        foreach (bkt_seen[k])
            touched += bkt_seen[k];
        $display("Summary: %0d requests issued, %0d results (%0d admitted, %0d dropped)",
                 issued_cnt, verdict_cnt, admit_seen, drop_seen);
        $display("Summary: %0d buckets filled, %0d mismatches", touched, error_cnt);
        if (error_cnt == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // Drop the run if it hangs.
    initial
    begin
        #2000000;
        $display("Timeout: %0d of %0d results seen", verdict_cnt, issued_cnt);
        $display("testbench: done, errors");
        $finish;
    end

endmodule
